@@ src/scc_pkg.sv @@
// Shared package for the strongly connected components unit.
// Holds field widths, sizing defaults and the controller/datapath command and status types.
// No dependencies.
package scc_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;
  localparam int unsigned VtxW        = 6;
  localparam int unsigned CntW        = 7;

  typedef struct packed {
    logic load;
    logic init;
    logic sel_next;
    logic enter_root;
    logic edge_rd;
    logic edge_eval;
    logic disc_upd;
    logic close_rd;
    logic close_wr;
    logic pop_rd;
    logic pop_wr;
    logic out_rd;
    logic out_ld;
    logic out_next;
  } scc_cmd_t;

  typedef struct packed {
    logic last_req;
    logic s_end;
    logic s_seen;
    logic k_end;
    logic back_edge;
    logic is_root;
    logic w_is_u;
    logic cs_empty;
    logic out_taken;
    logic last_i;
  } scc_sts_t;

endpackage

@@ src/scc_ctrl.sv @@
// Controller state machine of the strongly connected components unit.
// Sequences loading, the depth-first search and the result sweep; depends on scc_pkg.
module scc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::scc_sts_t sts_i,
  output scc_pkg::scc_cmd_t cmd_o
);
  import scc_pkg::*;

  typedef enum logic [13:0] {
    StLoad = 14'b00000000000001,
    StInit = 14'b00000000000010,
    StSel  = 14'b00000000000100,
    StScan = 14'b00000000001000,
    StEdge = 14'b00000000010000,
    StDisc = 14'b00000000100000,
    StFin  = 14'b00000001000000,
    StClr  = 14'b00000010000000,
    StClw  = 14'b00000100000000,
    StPop  = 14'b00001000000000,
    StPopw = 14'b00010000000000,
    StOrd  = 14'b00100000000000,
    StOld  = 14'b01000000000000,
    StOwt  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StLoad: begin
        cmd_o.load = 1'b1;
        if (sts_i.last_req) state_d = StInit;
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StSel;
      end
      StSel: begin
        if (sts_i.s_end) begin
          state_d = StOrd;
        end else if (sts_i.s_seen) begin
          cmd_o.sel_next = 1'b1;
        end else begin
          cmd_o.enter_root = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        if (sts_i.k_end) begin
          state_d = StFin;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = StEdge;
        end
      end
      StEdge: begin
        cmd_o.edge_eval = 1'b1;
        state_d         = sts_i.back_edge ? StDisc : StScan;
      end
      StDisc: begin
        cmd_o.disc_upd = 1'b1;
        state_d        = StScan;
      end
      StFin: begin
        state_d = sts_i.is_root ? StClr : StPop;
      end
      StClr: begin
        cmd_o.close_rd = 1'b1;
        state_d        = StClw;
      end
      StClw: begin
        cmd_o.close_wr = 1'b1;
        state_d        = sts_i.w_is_u ? StPop : StClr;
      end
      StPop: begin
        if (sts_i.cs_empty) begin
          cmd_o.sel_next = 1'b1;
          state_d        = StSel;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = StPopw;
        end
      end
      StPopw: begin
        cmd_o.pop_wr = 1'b1;
        state_d      = StScan;
      end
      StOrd: begin
        cmd_o.out_rd = 1'b1;
        state_d      = StOld;
      end
      StOld: begin
        cmd_o.out_ld = 1'b1;
        state_d      = StOwt;
      end
      StOwt: begin
        if (sts_i.out_taken) begin
          cmd_o.out_next = 1'b1;
          state_d        = sts_i.last_i ? StLoad : StOrd;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/scc_datapath.sv @@
// Datapath of the strongly connected components unit: edge store, vertex and call stacks,
// discovery times, component table and output register. Depends on scc_pkg.
module scc_datapath #(
  parameter int unsigned MaxV = scc_pkg::MaxVertices,
  parameter int unsigned MaxE = scc_pkg::MaxEdges
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scc_pkg::scc_cmd_t          cmd_i,
  output scc_pkg::scc_sts_t          sts_o,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [scc_pkg::VtxW-1:0]   edge_source_i,
  input  logic [scc_pkg::VtxW-1:0]   edge_target_i,
  input  logic                       last_edge_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [scc_pkg::VtxW-1:0]   vertex_id_o,
  output logic [scc_pkg::VtxW-1:0]   component_id_o,
  output logic [scc_pkg::CntW-1:0]   component_total_o,
  output logic                       dropped_edges_o,
  output logic                       final_vertex_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [scc_pkg::CntW-1:0]   vertex_count_i
);
  import scc_pkg::*;

  localparam int unsigned VW  = $clog2(MaxV);
  localparam int unsigned CW  = $clog2(MaxV + 1);
  localparam int unsigned ECW = $clog2(MaxE + 1);
  localparam int unsigned EAW = (MaxE > 1) ? $clog2(MaxE) : 1;
  localparam int unsigned FW  = VW + ECW + 2 * CW;

  logic [CntW-1:0] vcount_q;
  logic [CW-1:0]   n_eff, n_q, s_q, low_q, disc_q, csp_q, vsp_q, clk_q, ccnt_q, clk_n;
  logic [ECW-1:0]  ecnt_q, k_q;
  logic            drop_q, out_valid_q;
  logic [VW-1:0]   u_q, i_q, ev, tgt;
  logic [MaxV-1:0] seen_q, onstk_q;

  logic [VtxW-1:0] efrom_mem [MaxE];
  logic [VtxW-1:0] eto_mem   [MaxE];
  logic [CW-1:0]   disc_mem  [MaxV];
  logic [FW-1:0]   cs_mem    [MaxV];
  logic [VW-1:0]   vs_mem    [MaxV];
  logic [VtxW-1:0] comp_mem  [MaxV];
  logic [VtxW-1:0] ef_rd, et_rd, comp_rd;
  logic [CW-1:0]   disc_rd;
  logic [FW-1:0]   cs_rd, push_w;
  logic [VW-1:0]   vs_rd, cs_u;
  logic [ECW-1:0]  cs_k;
  logic [CW-1:0]   cs_low, cs_disc;

  logic acc, edge_ok, match, tree, back, enter;

  always_comb begin
    if (vcount_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(vcount_q) > MaxV) begin
      n_eff = CW'(MaxV);
    end else begin
      n_eff = CW'(vcount_q);
    end
  end

  assign in_stall_o  = !cmd_i.load;
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && cmd_i.load;
  assign edge_ok     = (32'(edge_source_i) < 32'(n_eff)) && (32'(edge_target_i) < 32'(n_eff))
                       && (32'(ecnt_q) < MaxE);

  assign tgt   = et_rd[VW-1:0];
  assign match = (32'(ef_rd) == 32'(u_q)) && (32'(et_rd) < 32'(n_q));
  assign tree  = match && !seen_q[tgt];
  assign back  = match && seen_q[tgt] && onstk_q[tgt];
  assign enter = cmd_i.enter_root || (cmd_i.edge_eval && tree);
  assign ev    = cmd_i.enter_root ? s_q[VW-1:0] : tgt;
  assign clk_n = clk_q + CW'(1);

  assign push_w  = {u_q, k_q + ECW'(1), low_q, disc_q};
  assign cs_u    = cs_rd[FW-1 -: VW];
  assign cs_k    = cs_rd[2*CW +: ECW];
  assign cs_low  = cs_rd[CW +: CW];
  assign cs_disc = cs_rd[CW-1:0];

  assign sts_o.last_req  = acc && last_edge_i;
  assign sts_o.s_end     = (s_q == n_q);
  assign sts_o.s_seen    = seen_q[s_q[VW-1:0]];
  assign sts_o.k_end     = (k_q >= ecnt_q);
  assign sts_o.back_edge = back;
  assign sts_o.is_root   = (low_q == disc_q);
  assign sts_o.w_is_u    = (vs_rd == u_q);
  assign sts_o.cs_empty  = (csp_q == '0);
  assign sts_o.out_taken = out_valid_q && !out_stall_i;
  assign sts_o.last_i    = (32'(i_q) + 32'd1 == 32'(n_q));

  always_ff @(posedge clk_i) begin
    if (acc && edge_ok) begin
      efrom_mem[ecnt_q[EAW-1:0]] <= edge_source_i;
      eto_mem[ecnt_q[EAW-1:0]]   <= edge_target_i;
    end
    if (cmd_i.edge_rd) begin
      ef_rd <= efrom_mem[k_q[EAW-1:0]];
      et_rd <= eto_mem[k_q[EAW-1:0]];
    end
    if (enter) begin
      disc_mem[ev]             <= clk_n;
      vs_mem[vsp_q[VW-1:0]]    <= ev;
    end
    if (cmd_i.edge_eval && back) begin
      disc_rd <= disc_mem[tgt];
    end
    if (cmd_i.edge_eval && tree) begin
      cs_mem[csp_q[VW-1:0]] <= push_w;
    end
    if (cmd_i.pop_rd) begin
      cs_rd <= cs_mem[VW'(csp_q - CW'(1))];
    end
    if (cmd_i.close_rd) begin
      vs_rd <= vs_mem[VW'(vsp_q - CW'(1))];
    end
    if (cmd_i.close_wr) begin
      comp_mem[vs_rd] <= VtxW'(ccnt_q);
    end
    if (cmd_i.out_rd) begin
      comp_rd <= comp_mem[i_q];
    end
    if (cmd_i.out_ld) begin
      vertex_id_o       <= VtxW'(i_q);
      component_id_o    <= comp_rd;
      component_total_o <= CntW'(ccnt_q);
      dropped_edges_o   <= drop_q;
      final_vertex_o    <= sts_o.last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= CntW'(MaxVertices);
      n_q         <= '0;
      ecnt_q      <= '0;
      drop_q      <= 1'b0;
      s_q         <= '0;
      u_q         <= '0;
      k_q         <= '0;
      low_q       <= '0;
      disc_q      <= '0;
      csp_q       <= '0;
      vsp_q       <= '0;
      clk_q       <= '0;
      ccnt_q      <= '0;
      seen_q      <= '0;
      onstk_q     <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) vcount_q <= vertex_count_i;
      if (acc) begin
        if (edge_ok) ecnt_q <= ecnt_q + ECW'(1);
        else         drop_q <= 1'b1;
      end
      if (cmd_i.init) begin
        n_q     <= n_eff;
        s_q     <= '0;
        clk_q   <= '0;
        ccnt_q  <= '0;
        vsp_q   <= '0;
        csp_q   <= '0;
        seen_q  <= '0;
        onstk_q <= '0;
        i_q     <= '0;
      end
      if (cmd_i.sel_next) s_q <= s_q + CW'(1);
      if (enter) begin
        clk_q       <= clk_n;
        seen_q[ev]  <= 1'b1;
        onstk_q[ev] <= 1'b1;
        vsp_q       <= vsp_q + CW'(1);
        u_q         <= ev;
        k_q         <= '0;
        low_q       <= clk_n;
        disc_q      <= clk_n;
        if (cmd_i.edge_eval) csp_q <= csp_q + CW'(1);
      end
      if (cmd_i.edge_eval && !tree && !back) k_q <= k_q + ECW'(1);
      if (cmd_i.disc_upd) begin
        if (disc_rd < low_q) low_q <= disc_rd;
        k_q <= k_q + ECW'(1);
      end
      if (cmd_i.close_rd) vsp_q <= vsp_q - CW'(1);
      if (cmd_i.close_wr) begin
        onstk_q[vs_rd] <= 1'b0;
        if (sts_o.w_is_u) ccnt_q <= ccnt_q + CW'(1);
      end
      if (cmd_i.pop_rd) csp_q <= csp_q - CW'(1);
      if (cmd_i.pop_wr) begin
        u_q    <= cs_u;
        k_q    <= cs_k;
        disc_q <= cs_disc;
        low_q  <= (cs_low < low_q) ? cs_low : low_q;
      end
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      if (cmd_i.out_next) begin
        out_valid_q <= 1'b0;
        if (sts_o.last_i) begin
          ecnt_q <= '0;
          drop_q <= 1'b0;
          i_q    <= '0;
        end else begin
          i_q <= i_q + VW'(1);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_clk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) clk_q <= n_q)
    else $error("visit clock beyond vertex count");
  a_comp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) ccnt_q <= clk_q)
    else $error("more components than visited vertices");
  a_stack_nest: assert property (@(posedge clk_i) disable iff (!rst_ni) csp_q <= vsp_q)
    else $error("call stack deeper than vertex stack");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(ecnt_q) <= MaxE)
    else $error("edge count beyond capacity");
`endif

endmodule

@@ src/strongly_connected_components_unit.sv @@
// Strongly connected components unit (Tarjan search over a loaded edge list).
// Loading channel: one directed edge per request (source, target, last marker); the
// request with last_edge set closes the graph and starts the search. Edges naming a
// vertex not below the vertex count, or arriving with the store full, are dropped
// and reported through dropped_edges.
// Configuration channel: vertex_count_i written when cfg_valid_i and cfg_ready_o are high.
// Loading takes one edge per cycle. The search starts with an initialisation step, tries
// each start vertex in turn and ends the sweep after the last; for every vertex visited
// it scans every stored edge (edge store read, then evaluation), with a further step per
// back edge, then ends the vertex (end of scan, root check, vertex-stack pop, call-stack
// pop); the edge store has a single read port. Results follow: one per vertex, 0 upward,
// each read from the component table, then held until taken; final_vertex marks the last.
// in_stall_o is high from the last edge until the last result is taken.
// Stall on the result side holds the current result; the result sweep does not continue
// past it. Reset clears the graph and sets the vertex count to 64.
// Depends on scc_pkg, scc_ctrl and scc_datapath.
module strongly_connected_components_unit #(
  parameter int unsigned MaxV = scc_pkg::MaxVertices,
  parameter int unsigned MaxE = scc_pkg::MaxEdges
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [scc_pkg::VtxW-1:0] edge_source_i,
  input  logic [scc_pkg::VtxW-1:0] edge_target_i,
  input  logic                     last_edge_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [scc_pkg::VtxW-1:0] vertex_id_o,
  output logic [scc_pkg::VtxW-1:0] component_id_o,
  output logic [scc_pkg::CntW-1:0] component_total_o,
  output logic                     dropped_edges_o,
  output logic                     final_vertex_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [scc_pkg::CntW-1:0] vertex_count_i
);
  import scc_pkg::*;

  scc_cmd_t cmd;
  scc_sts_t sts;

  scc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  scc_datapath #(
    .MaxV (MaxV),
    .MaxE (MaxE)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .edge_source_i     (edge_source_i),
    .edge_target_i     (edge_target_i),
    .last_edge_i       (last_edge_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .vertex_id_o       (vertex_id_o),
    .component_id_o    (component_id_o),
    .component_total_o (component_total_o),
    .dropped_edges_o   (dropped_edges_o),
    .final_vertex_o    (final_vertex_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .vertex_count_i    (vertex_count_i)
  );

endmodule
